// ===== hw/rtl/rrls_pkg.sv =====
// rrls_pkg: operation and status codes, fixed field widths and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package rrls_pkg;

    localparam int LOC_W     = 8;   // coordinate port width
    localparam int RAND_W    = 32;  // random word width
    localparam int CNT_OUT_W = 13;  // count port width
    localparam int EXT_W     = 16;  // scratch width for sign extension

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic       init_wr;
        logic       capture;
        logic       map_rd;
        logic       list_rd_map;
        logic       ins_commit;
        logic       div_start;
        logic       list_rd_rem;
        logic       get_out;
        logic       list_rd_last;
        logic       drop_wr;
        logic       clr_count;
        logic       set_status;
        logic [1:0] status;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       present;
        logic       full;
        logic       empty;
        logic       div_done;
        logic       init_done;
        logic       out_free;
    } t_stat;

endpackage

// ===== hw/rtl/random_removal_location_set_unit.sv =====
// random_removal_location_set_unit: top level of the location set store.
// Joins rrls_ctrl and rrls_datapath; uses rrls_pkg.
`timescale 1ns / 1ps

// Request channel: i_valid/o_stall carry operation, location and random word.
// Result channel: o_valid/i_stall carry status, popped location, count and
// the empty flag, one result per request, in request order.
// The store holds distinct locations in a dense entry list plus a position
// map; a location is held when its map index lies below the count and the
// list entry there names it, so clear only zeroes the count.
// A pop waits on the bit-serial remainder unit, then does the list reads and the
// hole refill. One request is in work at a time; the next is taken once the
// current result sits in the output register, even while the receiver still
// stalls it.
// After reset all 2^(2*COORD_BITS) position map entries are swept to zero, one
// entry a cycle, with o_stall held high.
// While i_stall is high a valid result holds in the result register; a finished
// request then waits in the controller and o_stall stays high.
module random_removal_location_set_unit #(
    parameter int CAPACITY   = 4096,
    parameter int COORD_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_operation,
    input  logic [rrls_pkg::LOC_W-1:0]     i_loc_x,
    input  logic [rrls_pkg::LOC_W-1:0]     i_loc_y,
    input  logic [rrls_pkg::RAND_W-1:0]    i_random_word,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_status,
    output logic [rrls_pkg::LOC_W-1:0]     o_out_x,
    output logic [rrls_pkg::LOC_W-1:0]     o_out_y,
    output logic [rrls_pkg::CNT_OUT_W-1:0] o_count,
    output logic                           o_is_empty
);
    import rrls_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rrls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rrls_datapath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_operation),
        .i_loc_x       (i_loc_x),
        .i_loc_y       (i_loc_y),
        .i_random_word (i_random_word),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

endmodule

// ===== hw/rtl/rrls_rem.sv =====
// rrls_rem: restoring remainder unit, one quotient bit per cycle.
// Computes a 32-bit word modulo a nonzero divisor; uses rrls_pkg.
`timescale 1ns / 1ps

module rrls_rem #(
    parameter int DIV_W = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rrls_pkg::RAND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [DIV_W-1:0]           o_rem
);
    import rrls_pkg::*;

    localparam int CTR_W = $clog2(RAND_W + 1);

    logic [CTR_W-1:0]  r_ctr;
    logic [RAND_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_dsr;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W:0]    w_shift;
    logic [DIV_W:0]    w_sub;

    assign w_shift = {r_rem, r_dvd[RAND_W-1]};
    assign w_sub   = w_shift - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else if (i_start) begin
            r_ctr <= CTR_W'(RAND_W);
        end else if (r_ctr != '0) begin
            r_ctr <= r_ctr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_ctr != '0) begin
            r_dvd <= {r_dvd[RAND_W-2:0], 1'b0};
            if (w_shift >= {1'b0, r_dsr}) begin
                r_rem <= w_sub[DIV_W-1:0];
            end else begin
                r_rem <= w_shift[DIV_W-1:0];
            end
        end
    end

    assign o_done = (r_ctr == '0);
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/rrls_datapath.sv =====
// rrls_datapath: entry list and position map memories, count, remainder
// unit and result register. Driven by rrls_ctrl commands; uses rrls_pkg, rrls_rem.
`timescale 1ns / 1ps

module rrls_datapath #(
    parameter int CAPACITY   = 4096,
    parameter int COORD_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrls_pkg::t_cmd                i_cmd,
    output rrls_pkg::t_stat               o_stat,
    input  logic [1:0]                    i_operation,
    input  logic [rrls_pkg::LOC_W-1:0]    i_loc_x,
    input  logic [rrls_pkg::LOC_W-1:0]    i_loc_y,
    input  logic [rrls_pkg::RAND_W-1:0]   i_random_word,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [rrls_pkg::LOC_W-1:0]    o_out_x,
    output logic [rrls_pkg::LOC_W-1:0]    o_out_y,
    output logic [rrls_pkg::CNT_OUT_W-1:0] o_count,
    output logic                          o_is_empty
);
    import rrls_pkg::*;

    localparam int KEY_W     = 2 * COORD_BITS;
    localparam int MAP_DEPTH = 1 << KEY_W;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    function automatic logic [COORD_BITS-1:0] f_part(input logic [LOC_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = {{(EXT_W-LOC_W){v[LOC_W-1]}}, v};
        return e[COORD_BITS-1:0];
    endfunction

    function automatic logic [LOC_W-1:0] f_out(input logic [COORD_BITS-1:0] p);
        logic [EXT_W-1:0] e;
        e = {{(EXT_W-COORD_BITS){p[COORD_BITS-1]}}, p};
        return e[LOC_W-1:0];
    endfunction

    logic [KEY_W-1:0] r_list_mem [CAPACITY];
    logic [IDX_W-1:0] r_map_mem  [MAP_DEPTH];

    logic [1:0]        r_op;
    logic [KEY_W-1:0]  r_key;
    logic [RAND_W-1:0] r_rand;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_map_q;
    logic [KEY_W-1:0]  r_list_q;
    logic [CNT_W-1:0]  r_count;
    logic [KEY_W-1:0]  r_init_addr;
    logic              r_init_done;
    logic [1:0]        r_res_status;
    logic [LOC_W-1:0]  r_px;
    logic [LOC_W-1:0]  r_py;

    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [LOC_W-1:0]  r_o_x;
    logic [LOC_W-1:0]  r_o_y;
    logic [CNT_W-1:0]  r_o_count;
    logic              r_o_empty;

    logic              w_div_done;
    logic [CNT_W-1:0]  w_rem;
    logic [IDX_W-1:0]  w_last;
    logic [IDX_W-1:0]  w_list_raddr;
    logic              w_list_re;
    logic              w_out_free;

    rrls_rem #(
        .DIV_W (CNT_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rand),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_last     = IDX_W'(r_count - 1'b1);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        w_list_re    = 1'b1;
        w_list_raddr = w_last;
        if (i_cmd.list_rd_map) begin
            w_list_raddr = r_map_q;
        end else if (i_cmd.list_rd_rem) begin
            w_list_raddr = w_rem[IDX_W-1:0];
        end else if (!i_cmd.list_rd_last) begin
            w_list_re = 1'b0;
        end
    end

    // position map: written by the clearing sweep, insert and hole refill
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_wr) begin
            r_map_mem[r_init_addr] <= '0;
        end else if (i_cmd.ins_commit) begin
            r_map_mem[r_key] <= r_count[IDX_W-1:0];
        end else if (i_cmd.drop_wr) begin
            r_map_mem[r_list_q] <= r_idx;
        end
        if (i_cmd.map_rd) begin
            r_map_q <= r_map_mem[r_key];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_commit) begin
            r_list_mem[r_count[IDX_W-1:0]] <= r_key;
        end else if (i_cmd.drop_wr) begin
            r_list_mem[r_idx] <= r_list_q;
        end
        if (w_list_re) begin
            r_list_q <= r_list_mem[w_list_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_init_addr <= '0;
            r_init_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_init_addr <= r_init_addr + 1'b1;
                if (&r_init_addr) begin
                    r_init_done <= 1'b1;
                end
            end
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.ins_commit) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.drop_wr) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_operation;
            r_key        <= {f_part(i_loc_x), f_part(i_loc_y)};
            r_rand       <= i_random_word;
            r_res_status <= ST_OK;
            r_px         <= '0;
            r_py         <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status;
            end
            if (i_cmd.get_out) begin
                r_px <= f_out(r_list_q[KEY_W-1:COORD_BITS]);
                r_py <= f_out(r_list_q[COORD_BITS-1:0]);
            end
        end
        if (i_cmd.list_rd_map) begin
            r_idx <= r_map_q;
        end else if (i_cmd.list_rd_rem) begin
            r_idx <= w_rem[IDX_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_x      <= r_px;
            r_o_y      <= r_py;
            r_o_count  <= r_count;
            r_o_empty  <= (r_count == '0);
        end
    end

    // a location is held when its map index points below the count at itself
    always_comb begin
        o_stat           = '0;
        o_stat.op        = r_op;
        o_stat.present   = (CNT_W'(r_idx) < r_count) && (r_list_q == r_key);
        o_stat.full      = (r_count >= CNT_W'(CAPACITY));
        o_stat.empty     = (r_count == '0);
        o_stat.div_done  = w_div_done;
        o_stat.init_done = r_init_done;
        o_stat.out_free  = w_out_free;
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_o_status;
    assign o_out_x    = r_o_x;
    assign o_out_y    = r_o_y;
    assign o_count    = CNT_OUT_W'(r_o_count);
    assign o_is_empty = r_o_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_commit |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the count by one");

    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.drop_wr || i_cmd.div_start) |-> r_count != '0)
        else $error("drop or modulo on an empty store");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("result overwritten before it was taken");

endmodule

// ===== hw/rtl/rrls_ctrl.sv =====
// rrls_ctrl: sequencer for insert, remove, pop and clear requests.
// Issues rrls_pkg::t_cmd to rrls_datapath and reads back rrls_pkg::t_stat.
`timescale 1ns / 1ps

module rrls_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rrls_pkg::t_stat i_stat,
    output rrls_pkg::t_cmd  o_cmd
);
    import rrls_pkg::*;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_MAP_WAIT = 4'd3;
    localparam logic [3:0] S_CHECK    = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_POP_GET  = 4'd6;
    localparam logic [3:0] S_DROP     = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                if (i_stat.init_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.init_wr = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    OP_CLEAR: begin
                        o_cmd.clr_count = 1'b1;
                        n_state         = S_FINISH;
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                            n_state          = S_FINISH;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    default: begin
                        o_cmd.map_rd = 1'b1;
                        n_state      = S_MAP_WAIT;
                    end
                endcase
            end
            S_MAP_WAIT: begin
                o_cmd.list_rd_map = 1'b1;
                n_state           = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.op == OP_INSERT) begin
                    n_state = S_FINISH;
                    if (i_stat.present) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_MISS;
                    end else if (i_stat.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                    end else begin
                        o_cmd.ins_commit = 1'b1;
                    end
                end else if (!i_stat.present) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_MISS;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.list_rd_last = 1'b1;
                    n_state            = S_DROP;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.list_rd_rem = 1'b1;
                    n_state           = S_POP_GET;
                end
            end
            S_POP_GET: begin
                // popped entry is on the read port; fetch the last entry next
                o_cmd.get_out      = 1'b1;
                o_cmd.list_rd_last = 1'b1;
                n_state            = S_DROP;
            end
            S_DROP: begin
                o_cmd.drop_wr = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for random_removal_location_set_unit.
// Queue-fed request driver, result monitor, shadow location set for predictions.
// Depends on rrls_pkg and the top-level unit only.
`timescale 1ns / 1ps

module tb;
    import rrls_pkg::*;

    localparam int CAPACITY     = 4096;
    localparam int COORD_BITS   = 8;
    localparam int KEY_W        = 2 * COORD_BITS;
    localparam int MAP_DEPTH    = 1 << KEY_W;
    localparam int MAX_IDLE     = 12;
    localparam int RANDOM_REQS  = 680;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_MAX   = 10;
    // the reset sweep of the position map is the longest wait, the rest is far shorter
    localparam int STUCK_LIMIT  = 262144;

    typedef struct packed {
        logic [1:0]        op;
        logic [LOC_W-1:0]  x;
        logic [LOC_W-1:0]  y;
        logic [RAND_W-1:0] rnd;
    } t_loc_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [LOC_W-1:0]     x;
        logic [LOC_W-1:0]     y;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
    } t_loc_rsp;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_operation   = OP_INSERT;
    logic [LOC_W-1:0]     i_loc_x       = '0;
    logic [LOC_W-1:0]     i_loc_y       = '0;
    logic [RAND_W-1:0]    i_random_word = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [1:0]           o_status;
    logic [LOC_W-1:0]     o_out_x;
    logic [LOC_W-1:0]     o_out_y;
    logic [CNT_OUT_W-1:0] o_count;
    logic                 o_is_empty;

    random_removal_location_set_unit #(
        .CAPACITY  (CAPACITY),
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_loc_x      (i_loc_x),
        .i_loc_y      (i_loc_y),
        .i_random_word(i_random_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the location set
    logic [KEY_W-1:0] held_list [CAPACITY];
    int unsigned      slot_of   [MAP_DEPTH];
    bit               slot_live [MAP_DEPTH];
    int unsigned      held_count = 0;

    t_loc_req    req_queue[$];
    t_loc_rsp    due_replies[$];
    t_loc_req    drv_req;
    int unsigned reqs_total    = 0;
    int unsigned reqs_accepted = 0;
    int unsigned fail_count    = 0;
    int unsigned drv_idle      = 0;
    int unsigned mon_hold      = 0;
    bit          drv_quiet     = 1'b0;
    bit          mon_quiet     = 1'b0;
    int unsigned stuck_cycles  = 0;

    function automatic logic [COORD_BITS-1:0] key_part(input logic [LOC_W-1:0] c);
        logic [EXT_W-1:0] e;
        e = {{(EXT_W - LOC_W){c[LOC_W-1]}}, c};
        return e[COORD_BITS-1:0];
    endfunction

    function automatic logic [LOC_W-1:0] out_part(input logic [COORD_BITS-1:0] p);
        logic [EXT_W-1:0] e;
        e = {{(EXT_W - COORD_BITS){p[COORD_BITS-1]}}, p};
        return e[LOC_W-1:0];
    endfunction

    function automatic int unsigned draw_idle(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // swap-remove: the last entry fills the hole at k
    task automatic drop_slot(input int unsigned k);
        int unsigned      last;
        logic [KEY_W-1:0] gone;
        last = held_count - 1;
        gone = held_list[k];
        if (k != last) begin
            held_list[k]            = held_list[last];
            slot_of[held_list[last]] = k;
        end
        slot_live[gone] = 1'b0;
        held_count      = last;
    endtask

    task automatic model_set_op(input t_loc_req r);
        logic [KEY_W-1:0] key;
        t_loc_rsp         rsp;
        int unsigned      k;
        int unsigned      i;
        key        = {key_part(r.x), key_part(r.y)};
        rsp        = '0;
        rsp.status = ST_OK;
        case (r.op)
            OP_INSERT: begin
                if (slot_live[key]) begin
                    rsp.status = ST_MISS;
                end else if (held_count >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    held_list[held_count] = key;
                    slot_of[key]          = held_count;
                    slot_live[key]        = 1'b1;
                    held_count++;
                end
            end
            OP_REMOVE: begin
                if (!slot_live[key]) begin
                    rsp.status = ST_MISS;
                end else begin
                    k = slot_of[key];
                    if (k < held_count) drop_slot(k);
                    else slot_live[key] = 1'b0;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    k     = r.rnd % held_count;
                    rsp.x = out_part(held_list[k][KEY_W-1:COORD_BITS]);
                    rsp.y = out_part(held_list[k][COORD_BITS-1:0]);
                    drop_slot(k);
                end
            end
            default: begin
                for (i = 0; i < held_count; i++) slot_live[held_list[i]] = 1'b0;
                held_count = 0;
            end
        endcase
        rsp.count = CNT_OUT_W'(held_count);
        rsp.empty = (held_count == 0);
        due_replies.insert(due_replies.size(), rsp);
    endtask

    task automatic check_reply();
        t_loc_rsp exp;
        bit       bad;
        if (due_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("unexpected result: status=%0d x=%0d y=%0d count=%0d empty=%0d",
                         o_status, $signed(o_out_x), $signed(o_out_y), o_count, o_is_empty);
        end else begin
            exp = due_replies.pop_front();
            bad = (o_status !== exp.status) || (o_out_x !== exp.x) || (o_out_y !== exp.y)
                  || (o_count !== exp.count) || (o_is_empty !== exp.empty);
            if (bad) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display({"mismatch: exp status=%0d x=%0d y=%0d count=%0d empty=%0d,",
                              " got status=%0d x=%0d y=%0d count=%0d empty=%0d"},
                             exp.status, $signed(exp.x), $signed(exp.y), exp.count,
                             exp.empty, o_status, $signed(o_out_x), $signed(o_out_y),
                             o_count, o_is_empty);
            end
        end
    endtask

    task automatic push_req(input logic [1:0] op, input logic [LOC_W-1:0] x,
                            input logic [LOC_W-1:0] y, input logic [RAND_W-1:0] rnd);
        t_loc_req r;
        r.op  = op;
        r.x   = x;
        r.y   = y;
        r.rnd = rnd;
        req_queue.insert(req_queue.size(), r);
        reqs_total++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                model_set_op(drv_req);
                reqs_accepted++;
                if ($urandom_range(0, 29) == 0) drv_quiet = !drv_quiet;
                drv_idle = draw_idle(drv_quiet);
            end
            if (drv_idle == 0 && req_queue.size() != 0) begin
                drv_req = req_queue.pop_front();
                i_valid       <= 1'b1;
                i_operation   <= drv_req.op;
                i_loc_x       <= drv_req.x;
                i_loc_y       <= drv_req.y;
                i_random_word <= drv_req.rnd;
            end else begin
                if (drv_idle != 0) drv_idle--;
                // junk on the idle payload
                i_valid       <= 1'b0;
                i_operation   <= 2'($urandom);
                i_loc_x       <= LOC_W'($urandom);
                i_loc_y       <= LOC_W'($urandom);
                i_random_word <= $urandom;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_reply();
                if ($urandom_range(0, 29) == 0) mon_quiet = !mon_quiet;
                mon_hold = draw_idle(mon_quiet);
            end else if (o_valid && mon_hold != 0) begin
                mon_hold--;
            end
            i_stall <= (mon_hold != 0);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("** random_removal_location_set_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int unsigned      n;
        int unsigned      pick;
        logic [LOC_W-1:0] bx;
        logic [LOC_W-1:0] by;
        logic [LOC_W-1:0] rx;
        logic [LOC_W-1:0] ry;
        logic [1:0]       rop;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store corner cases
        push_req(OP_POP,    8'h00, 8'h00, 32'h0000_0000);
        push_req(OP_REMOVE, 8'h00, 8'h00, $urandom);
        push_req(OP_CLEAR,  8'h00, 8'h00, $urandom);
        // coordinate extremes
        push_req(OP_INSERT, 8'h80, 8'h80, $urandom);
        push_req(OP_INSERT, 8'h7F, 8'h7F, $urandom);
        push_req(OP_INSERT, 8'h80, 8'h7F, $urandom);
        push_req(OP_INSERT, 8'h7F, 8'h80, $urandom);
        push_req(OP_INSERT, 8'h00, 8'h00, $urandom);
        push_req(OP_INSERT, 8'hFF, 8'h01, $urandom);
        push_req(OP_INSERT, 8'h7F, 8'h7F, $urandom);
        // remove from the middle, then the last entry, then absent
        push_req(OP_REMOVE, 8'h00, 8'h00, $urandom);
        push_req(OP_REMOVE, 8'hFF, 8'h01, $urandom);
        push_req(OP_REMOVE, 8'h00, 8'h00, $urandom);
        // pop the last entry, the first entry, then anywhere
        push_req(OP_POP,    8'h00, 8'h00, 32'hFFFF_FFFF);
        push_req(OP_POP,    8'h00, 8'h00, 32'h0000_0000);
        push_req(OP_POP,    8'h00, 8'h00, $urandom);
        push_req(OP_INSERT, 8'h55, 8'hAA, $urandom);
        push_req(OP_CLEAR,  8'h00, 8'h00, $urandom);
        push_req(OP_POP,    8'h00, 8'h00, $urandom);
        // a location popped before the clear can be inserted again
        push_req(OP_INSERT, 8'h80, 8'h80, $urandom);
        push_req(OP_REMOVE, 8'h80, 8'h80, $urandom);
        push_req(OP_CLEAR,  8'h00, 8'h00, $urandom);

        // random traffic over a small moving window so hits are common
        bx = '0;
        by = '0;
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                bx = LOC_W'($urandom);
                by = LOC_W'($urandom);
            end
            rx = bx + LOC_W'($urandom_range(0, 7));
            ry = by + LOC_W'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 8) begin
                rx = LOC_W'($urandom);
                ry = LOC_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)      rop = OP_INSERT;
            else if (pick < 65) rop = OP_REMOVE;
            else if (pick < 95) rop = OP_POP;
            else                rop = OP_CLEAR;
            push_req(rop, rx, ry, $urandom);
        end

        while (reqs_accepted != reqs_total) @(posedge i_clk);
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_replies.size() == 0) begin
            $display("** random_removal_location_set_unit: PASSED **");
        end else begin
            $display("** random_removal_location_set_unit: FAILED **");
        end
        $finish;
    end

endmodule
